@@ rtl/cgl_pkg.sv @@
// ----------------------------------------------------------------------------
// cgl_pkg
// Shared constants and types for the color gradient ramp.
// ----------------------------------------------------------------------------
package cgl_pkg;

    localparam int MAX_STOPS_DEF = 7;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int COLOR_W    = CH_W * NUM_CH;
    localparam int COUNT_W    = 3;
    localparam int STOP_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR0 = 3'd1;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                  black;
        logic [STOP_IDX_W-1:0] idx;
    } t_cmd;

endpackage

@@ rtl/cgl_front.sv @@
// ----------------------------------------------------------------------------
// cgl_front
// Accepts positions and classifies them into a segment index and a blend
// fraction, or an opaque black result.
// ----------------------------------------------------------------------------
module cgl_front #(
    parameter int MAX_STOPS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [FRAC_BITS+1:0]   i_t_position,
    input  logic [cgl_pkg::COUNT_W-1:0]   i_count,
    output logic                          o_push,
    output cgl_pkg::t_cmd                 o_cmd,
    output logic [FRAC_BITS-1:0]          o_frac,
    input  logic                          i_full
);
    import cgl_pkg::*;

    logic [COUNT_W-1:0]     cnt_eff;
    logic [COUNT_W-1:0]     cnt_m1;
    logic                   t_low;
    logic                   t_high;
    logic [FRAC_BITS+2:0]   scaled;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        cnt_eff = (i_count > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : i_count;
        cnt_m1  = cnt_eff - COUNT_W'(1);
        t_low   = i_t_position[FRAC_BITS+1] || (i_t_position == '0);
        t_high  = !i_t_position[FRAC_BITS+1] && i_t_position[FRAC_BITS];
        scaled  = (FRAC_BITS+3)'(i_t_position[FRAC_BITS-1:0]) * (FRAC_BITS+3)'(cnt_m1);

        o_cmd.black = 1'b0;
        o_cmd.idx   = '0;
        o_frac      = '0;
        if (cnt_eff == '0) begin
            o_cmd.black = 1'b1;
        end else if (cnt_eff == COUNT_W'(1) || t_low) begin
            o_cmd.idx = '0;
        end else if (t_high) begin
            o_cmd.idx = STOP_IDX_W'(cnt_m1);
        end else begin
            o_cmd.idx = scaled[FRAC_BITS+2:FRAC_BITS];
            o_frac    = scaled[FRAC_BITS-1:0];
        end
    end

endmodule

@@ rtl/cgl_queue.sv @@
// ----------------------------------------------------------------------------
// cgl_queue
// Short queue that decouples classification from the blend pipeline.
// ----------------------------------------------------------------------------
module cgl_queue #(
    parameter int WIDTH = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import cgl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push);
        n_rd_ptr = r_rd_ptr + PTR_W'(i_pop);
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not advance on push");

endmodule

@@ rtl/cgl_back.sv @@
// ----------------------------------------------------------------------------
// cgl_back
// Two-stage blend pipeline: channel differences times fraction, then add
// the floored step to the lower stop, or give opaque black.
// ----------------------------------------------------------------------------
module cgl_back #(
    parameter int MAX_STOPS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_pop,
    input  cgl_pkg::t_cmd                                    i_cmd,
    input  logic [FRAC_BITS-1:0]                             i_frac,
    input  logic [MAX_STOPS-1:0][cgl_pkg::COLOR_W-1:0]       i_colors,
    output logic                                             o_valid,
    input  logic                                             i_ready,
    output logic [cgl_pkg::CH_W-1:0]                         o_red,
    output logic [cgl_pkg::CH_W-1:0]                         o_green,
    output logic [cgl_pkg::CH_W-1:0]                         o_blue,
    output logic [cgl_pkg::CH_W-1:0]                         o_alpha
);
    import cgl_pkg::*;

    localparam int IDX_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int PROD_W = CH_W + FRAC_BITS + 2;

    logic [MAX_STOPS-1:0][2*COLOR_W-1:0] pair;
    logic [2*COLOR_W-1:0]                sel;
    logic [COLOR_W-1:0]                  c_lo;
    logic [COLOR_W-1:0]                  c_hi;
    logic signed [FRAC_BITS:0]           frac_s;
    logic signed [CH_W:0]                diff [NUM_CH];
    logic signed [PROD_W-1:0]            prod [NUM_CH];
    logic [CH_W-1:0]                     sum  [NUM_CH];

    logic                     r_s1_valid;
    logic                     r_s1_black;
    logic [CH_W-1:0]          r_s1_base [NUM_CH];
    logic signed [PROD_W-1:0] r_s1_prod [NUM_CH];
    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out [NUM_CH];

    logic adv_out;
    logic load_s1;

    always_comb begin
        for (int k = 0; k < MAX_STOPS; k++) begin
            if (k == MAX_STOPS - 1) begin
                pair[k] = {i_colors[k], i_colors[k]};
            end else begin
                pair[k] = {i_colors[k+1], i_colors[k]};
            end
        end
    end

    assign sel    = pair[i_cmd.idx[IDX_W-1:0]];
    assign c_lo   = sel[COLOR_W-1:0];
    assign c_hi   = sel[2*COLOR_W-1:COLOR_W];
    assign frac_s = {1'b0, i_frac};

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            diff[ch] = $signed({1'b0, c_hi[COLOR_W-1-CH_W*ch -: CH_W]})
                     - $signed({1'b0, c_lo[COLOR_W-1-CH_W*ch -: CH_W]});
            prod[ch] = PROD_W'(diff[ch]) * PROD_W'(frac_s);
            sum[ch]  = r_s1_base[ch] + r_s1_prod[ch][FRAC_BITS +: CH_W];
        end
    end

    assign adv_out = r_s1_valid && (!r_out_valid || i_ready);
    assign load_s1 = !r_s1_valid || adv_out;
    assign o_pop   = i_valid && load_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_s1) begin
                r_s1_valid <= i_valid;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_black <= i_cmd.black;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s1_base[ch] <= c_lo[COLOR_W-1-CH_W*ch -: CH_W];
                r_s1_prod[ch] <= prod[ch];
            end
        end
        if (adv_out) begin
            if (r_s1_black) begin
                r_out[0] <= '0;
                r_out[1] <= '0;
                r_out[2] <= '0;
                r_out[3] <= ALPHA_OPAQUE;
            end else begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r_out[ch] <= sum[ch];
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
    assign o_alpha = r_out[3];

    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("blend stage stalled with empty output");

endmodule

@@ rtl/color_gradient_lerp.sv @@
// ----------------------------------------------------------------------------
// color_gradient_lerp
// Piecewise-linear RGBA8 color ramp over up to seven configurable stops.
// An accepted input passes through the queue write, the multiply stage and the
// output register. Throughput: one item per cycle while the output is not
// stalled, set by the single blend pipeline. Reset is synchronous, active low:
// stop count and stop colors clear to zero, queue and pipeline empty.
// ----------------------------------------------------------------------------
module color_gradient_lerp #(
    parameter int MAX_STOPS = cgl_pkg::MAX_STOPS_DEF,
    parameter int FRAC_BITS = cgl_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cgl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cgl_pkg::COLOR_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [FRAC_BITS+1:0]       i_t_position,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cgl_pkg::CH_W-1:0]          o_red,
    output logic [cgl_pkg::CH_W-1:0]          o_green,
    output logic [cgl_pkg::CH_W-1:0]          o_blue,
    output logic [cgl_pkg::CH_W-1:0]          o_alpha
);
    import cgl_pkg::*;

    localparam int Q_W = $bits(t_cmd) + FRAC_BITS;

    logic [COUNT_W-1:0]                r_count;
    logic [MAX_STOPS-1:0][COLOR_W-1:0] r_colors;

    logic                 push;
    logic                 full;
    t_cmd                 f_cmd;
    logic [FRAC_BITS-1:0] f_frac;
    logic                 q_valid;
    logic                 q_pop;
    logic [Q_W-1:0]       q_data;
    t_cmd                 b_cmd;
    logic [FRAC_BITS-1:0] b_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_colors <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_COUNT) begin
                r_count <= i_cfg_data[COUNT_W-1:0];
            end
            for (int k = 0; k < MAX_STOPS; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(REG_COLOR0 + CFG_IDX_W'(k))) begin
                    r_colors[k] <= i_cfg_data;
                end
            end
        end
    end

    cgl_front #(
        .MAX_STOPS (MAX_STOPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_t_position (i_t_position),
        .i_count      (r_count),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .o_frac       (f_frac),
        .i_full       (full)
    );

    cgl_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_frac}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign b_cmd  = q_data[Q_W-1:FRAC_BITS];
    assign b_frac = q_data[FRAC_BITS-1:0];

    cgl_back #(
        .MAX_STOPS (MAX_STOPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_cmd    (b_cmd),
        .i_frac   (b_frac),
        .i_colors (r_colors),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue),
        .o_alpha  (o_alpha)
    );

    a_black_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_count == '0) |->
            (o_red == '0 && o_green == '0 && o_blue == '0 && o_alpha == ALPHA_OPAQUE))
        else $error("no stops but result is not opaque black");

endmodule
